/* rtl/core/i2d_pkg.sv */
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared types and constants for the signed 16-bit to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2d_pkg;

    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned MAG_W       = 15;
    localparam int unsigned DIGITS      = 5;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned CHAR_W      = 8;

    localparam int unsigned RADIX       = 10;
    // x / 10 == (x * 52429) >> 19 for every x below 2**16
    localparam int unsigned RADIX_RECIP = 52429;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned PROD_W      = 32;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_NONE  = 8'h00;

    localparam logic [VALUE_W-1:0] MOST_NEG   = 16'h8000;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // One converted value waiting for the emitter
    typedef struct packed {
        logic                             err;
        logic                             neg;
        logic [POS_W-1:0]                 first;   // highest digit to print
        logic [DIGITS-1:0][DIGIT_W-1:0]   digits;  // digits[0] is units
    } t_item;

endpackage

/* rtl/core/int16_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// int16_to_decimal_ascii
// Signed 16-bit integer to decimal ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
// Conversion: five divide-by-ten steps through the single reciprocal
//   multiplier, then the handoff to the queue, in which the next value can
//   be taken; the emitter sends one character per cycle unless the output
//   stalls.
// Reset: synchronous, active low; empties the queue and output register.
module int16_to_decimal_ascii
    import i2d_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [CHAR_W-1:0]         o_char_code,
    output logic                      o_last_char,
    output logic                      o_range_error
);

    logic  push;
    t_item push_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_data;
    logic  q_pop;

    i2d_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_value    (i_value),
        .o_push     (push),
        .o_item     (push_item),
        .i_q_ready  (q_ready)
    );

    i2d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    i2d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_code   (o_char_code),
        .o_last_char   (o_last_char),
        .o_range_error (o_range_error)
    );

endmodule

/* rtl/core/i2d_front.sv */
// ----------------------------------------------------------------------------
// i2d_front
// Accepts a value, flags the unrepresentable one, takes the magnitude and
// splits it into five decimal digits, one divide-by-ten step per cycle.
// ----------------------------------------------------------------------------
module i2d_front
    import i2d_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_push,
    output t_item                     o_item,
    input  logic                      i_q_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_PUSH
    } t_state;

    t_state                            r_state;
    logic [POS_W-1:0]                  r_cnt;
    logic [MAG_W-1:0]                  r_mag;
    logic [DIGITS-1:0][DIGIT_W-1:0]    r_dig;
    logic                              r_neg;
    logic                              r_err;

    logic                              accept;
    logic [VALUE_W-1:0]                raw;
    logic [VALUE_W-1:0]                neg_raw;
    logic [MAG_W-1:0]                  n_mag;
    logic [PROD_W-1:0]                 prod;
    logic [MAG_W-1:0]                  quot;
    logic [MAG_W-1:0]                  quot10;
    logic [DIGIT_W-1:0]                digit;
    logic [POS_W-1:0]                  first;

    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_PUSH) && i_q_ready);
    assign accept     = i_in_valid && o_in_ready;

    assign raw     = i_value;
    assign neg_raw = ~raw + VALUE_W'(1);
    // most negative value folds to zero here; it is flagged separately
    assign n_mag   = raw[VALUE_W-1] ? neg_raw[MAG_W-1:0] : raw[MAG_W-1:0];

    assign prod   = PROD_W'(r_mag) * PROD_W'(RADIX_RECIP);
    assign quot   = MAG_W'(prod >> RECIP_SHIFT);
    assign quot10 = MAG_W'(quot * MAG_W'(RADIX));
    assign digit  = DIGIT_W'(r_mag - quot10);

    always_comb begin
        priority if (r_dig[4] != '0) begin
            first = POS_W'(4);
        end else if (r_dig[3] != '0) begin
            first = POS_W'(3);
        end else if (r_dig[2] != '0) begin
            first = POS_W'(2);
        end else if (r_dig[1] != '0) begin
            first = POS_W'(1);
        end else begin
            first = '0;
        end
    end

    assign o_push        = (r_state == S_PUSH) && i_q_ready;
    assign o_item.err    = r_err;
    assign o_item.neg    = r_neg;
    assign o_item.first  = first;
    assign o_item.digits = r_dig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CONV;
                        r_cnt   <= '0;
                    end
                end
                S_CONV: begin
                    r_cnt <= r_cnt + POS_W'(1);
                    if (r_cnt == POS_W'(DIGITS - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (accept) begin
                        r_state <= S_CONV;
                        r_cnt   <= '0;
                    end else if (i_q_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag <= n_mag;
            r_neg <= raw[VALUE_W-1];
            r_err <= (raw == MOST_NEG);
        end else if (r_state == S_CONV) begin
            r_mag <= quot;
            // units digit comes out first and ends up in the lowest slot
            r_dig <= {digit, r_dig[DIGITS-1:1]};
        end
    end

endmodule

/* rtl/core/i2d_queue.sv */
// ----------------------------------------------------------------------------
// i2d_queue
// Small FIFO of converted values between the converter and the emitter.
// ----------------------------------------------------------------------------
module i2d_queue
    import i2d_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_data,
    input  logic  i_pop
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/core/i2d_back.sv */
// ----------------------------------------------------------------------------
// i2d_back
// Walks one converted value out into the output reg: sign, then digits from
// the top non-zero one to units (NUL if flagged), one per cycle unless stalled.
// ----------------------------------------------------------------------------
module i2d_back
    import i2d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_q_data,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_last_char,
    output logic              o_range_error
);

    logic              r_act;
    t_item             r_item;
    logic              r_sign;
    logic [POS_W-1:0]  r_pos;

    logic              r_ovalid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_err;

    logic              adv;
    logic              emit;
    logic              cur_last;
    logic [CHAR_W-1:0] cur_char;

    assign adv  = !r_ovalid || i_out_ready;
    assign emit = r_act && adv;

    always_comb begin
        priority if (r_item.err) begin
            cur_char = ASCII_NONE;
            cur_last = 1'b1;
        end else if (r_sign) begin
            cur_char = ASCII_MINUS;
            cur_last = 1'b0;
        end else begin
            cur_char = ASCII_ZERO + CHAR_W'(r_item.digits[r_pos]);
            cur_last = (r_pos == '0);
        end
    end

    assign o_q_pop = i_q_valid && (!r_act || (emit && cur_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_act <= 1'b1;
            end else if (emit && cur_last) begin
                r_act <= 1'b0;
            end
            if (adv) begin
                r_ovalid <= r_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_data;
            r_sign <= i_q_data.neg && !i_q_data.err;
            r_pos  <= i_q_data.first;
        end else if (emit) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (r_pos != '0) begin
                r_pos <= r_pos - POS_W'(1);
            end
        end
        if (emit) begin
            r_char <= cur_char;
            r_last <= cur_last;
            r_err  <= r_item.err;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_char_code   = r_char;
    assign o_last_char   = r_last;
    assign o_range_error = r_err;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks int16_to_decimal_ascii: signed values go in, decimal text characters
// come out and are compared field by field with a behavioral prediction. The
// sender runs in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2d_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              err;
    } t_char;

    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 drain;  // hold off until all text has come back
    } t_send;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [CHAR_W-1:0]         o_char_code;
    logic                      o_last_char;
    logic                      o_range_error;

    t_send  value_q [$];
    t_char  text_q [$];
    int     bad_count = 0;
    int     n_loaded = 0;
    int     n_taken = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    logic [15:0] ready_pat = 16'hFFFF;
    int     mode_left = 0;

    int16_to_decimal_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_code   (o_char_code),
        .o_last_char   (o_last_char),
        .o_range_error (o_range_error)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        bad_count++;
    endtask

    // Expected characters for one value: sign, digits with leading zeros
    // dropped, units digit always present; the most negative value gives one NUL.
    task automatic predict_text(input logic [VALUE_W-1:0] raw);
        int unsigned       mag;
        logic [DIGIT_W-1:0] dig [DIGITS];
        logic [CHAR_W-1:0] txt [$];
        bit                shown;
        t_char             c;
        shown = 1'b0;
        if (raw == MOST_NEG) begin
            c.code = ASCII_NONE;
            c.last = 1'b1;
            c.err  = 1'b1;
            text_q.push_back(c);
            return;
        end
        mag = raw[VALUE_W-1] ? (32'h1_0000 - raw) : raw;
        for (int k = 0; k < DIGITS; k++) begin
            dig[k] = DIGIT_W'(mag % RADIX);
            mag    = mag / RADIX;
        end
        if (raw[VALUE_W-1])
            txt.push_back(ASCII_MINUS);
        for (int k = DIGITS - 1; k >= 1; k--) begin
            if (shown || dig[k] != 0) begin
                txt.push_back(ASCII_ZERO + dig[k]);
                shown = 1'b1;
            end
        end
        txt.push_back(ASCII_ZERO + dig[0]);
        foreach (txt[k]) begin
            c.code = txt[k];
            c.last = (k == txt.size() - 1);
            c.err  = 1'b0;
            text_q.push_back(c);
        end
    endtask

    task automatic load_value(input logic [VALUE_W-1:0] v, input bit drain);
        t_send s;
        s.value = v;
        s.drain = drain;
        value_q.push_back(s);
        n_loaded++;
    endtask

    // Sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        bit    took;
        t_send s;
        took = i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (took) begin
                predict_text(i_value);
                n_taken++;
            end
            if (i_in_valid && !took) begin
                // hold the pending transaction
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (value_q.size() > 0 &&
                         !(value_q[0].drain && text_q.size() != 0)) begin
                s = value_q.pop_front();
                i_in_valid <= 1'b1;
                i_value    <= s.value;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(24, 1);
                    gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 1);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each character, then step the stall pattern
    always @(posedge i_clk) begin
        t_char want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (text_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %h", o_char_code));
                end else begin
                    want = text_q.pop_front();
                    if (o_char_code !== want.code)
                        report_mismatch($sformatf("char_code %h, want %h",
                                                  o_char_code, want.code));
                    if (o_last_char !== want.last)
                        report_mismatch($sformatf("last_char %b, want %b",
                                                  o_last_char, want.last));
                    if (o_range_error !== want.err)
                        report_mismatch($sformatf("range_error %b, want %b",
                                                  o_range_error, want.err));
                end
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(200, 20);
                case ($urandom_range(2))
                    0:       ready_pat = 16'hFFFF;
                    1:       ready_pat = 16'($urandom);
                    default: ready_pat = 16'($urandom & $urandom & $urandom);
                endcase
                if (ready_pat == '0)
                    ready_pat = 16'h0001;
            end else begin
                mode_left--;
            end
            i_out_ready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
    end

    initial begin
        int unsigned nd;
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;

        // directed: extremes, digit-count boundaries, most negative value
        load_value(16'sd0, 1'b0);
        load_value(16'sd1, 1'b0);
        load_value(-16'sd1, 1'b0);
        load_value(16'sd9, 1'b0);
        load_value(16'sd10, 1'b0);
        load_value(-16'sd10, 1'b0);
        load_value(16'sd99, 1'b0);
        load_value(16'sd100, 1'b0);
        load_value(-16'sd999, 1'b0);
        load_value(16'sd1000, 1'b0);
        load_value(16'sd9999, 1'b0);
        load_value(-16'sd10000, 1'b0);
        load_value(16'sd10000, 1'b0);
        load_value(16'sd32767, 1'b0);
        load_value(-16'sd32767, 1'b0);
        load_value(MOST_NEG, 1'b0);
        load_value(MOST_NEG, 1'b0);
        load_value(16'sd12345, 1'b0);
        load_value(-16'sd9, 1'b0);
        load_value(16'h5555, 1'b0);
        load_value(16'hAAAA, 1'b0);
        load_value(16'sd10101, 1'b0);
        load_value(-16'sd20000, 1'b0);
        load_value(MOST_NEG, 1'b1);

        for (int n = 0; n < 286; n++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: mag = $urandom_range(16'hFFFF);
                8: begin
                    case ($urandom_range(3))
                        0:       mag = MOST_NEG;
                        1:       mag = 0;
                        2:       mag = 16'h7FFF;
                        default: mag = 16'h8001;
                    endcase
                end
                default: begin
                    nd = $urandom_range(5, 1);
                    lo = (nd == 1) ? 0 : 10 ** (nd - 1);
                    hi = (nd == 5) ? 32767 : 10 ** nd - 1;
                    mag = $urandom_range(hi, lo);
                    if ($urandom_range(1))
                        mag = 32'h1_0000 - mag;
                end
            endcase
            load_value(mag[VALUE_W-1:0], n == 143);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken != n_loaded) @(posedge i_clk);
        while (text_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (bad_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d characters outstanding", text_q.size());
        $display("FAILURE");
        $finish;
    end

endmodule
